FILE: design/bti_pkg.sv
// Shared types and constants for the bilinear table interpolator.
// Used by bti_ctrl, bti_dp and the top level; no dependencies.
package bti_pkg;

    localparam int NUM_TABLES_DEF  = 10;
    localparam int TABLE_WORDS_DEF = 1024;
    localparam int HDR_WORDS       = 6;
    localparam int NUM_SLOTS       = 10;

    localparam logic [3:0] SLOT_LAST_HDR  = 4'd5;
    localparam logic [3:0] SLOT_FIRST_GRD = 4'd6;
    localparam logic [3:0] SLOT_LAST_GRD  = 4'd9;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_TABLE = 2'd1,
        ST_RANGE     = 2'd2
    } t_status;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_INTERP = 1'b1
    } t_op;

    typedef struct packed {
        logic       wr;
        logic       load_in;
        logic       cap;
        logic [3:0] slot;
        logic       axis;
        logic       div_start;
        logic       cap_ax;
        logic       mul_n;
        logic       n_load;
        logic       m1;
        logic       m2;
        logic       a1;
        logic       m3;
        logic       a2;
        logic       out_load;
        t_status    status;
    } t_cmd;

    typedef struct packed {
        logic sel_ok;
        logic pre_fail;
        logic div_done;
        logic idx_fail;
        logic grid_fail;
        logic out_free;
    } t_stat;

endpackage

FILE: design/bilinear_table_interpolator.sv
// Top level of the bilinear table interpolator: controller plus datapath.
// Depends on bti_pkg, bti_ctrl, bti_dp (which holds bti_div).
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_stall   op, table_select, word_address,
//                                                 word_value, x/y position, x/y offset
//   out      output     o_out_valid / i_out_stall status, value
//
// A write transfer is taken while idle and written without leaving the idle state.
// A lookup reads the six header words, each through a read and a capture state,
// runs the 50-step shared divider for x and y in turn, reads four grid words and
// blends in five steps; it ends early when the table select or a bounds check fails.
// Reset is synchronous, active low, and clears the control state only.
// A result stalled at the output does not block the next input transfer.
module bilinear_table_interpolator import bti_pkg::*; #(
    parameter int NUM_TABLES  = NUM_TABLES_DEF,
    parameter int TABLE_WORDS = TABLE_WORDS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_op,
    input  logic [3:0]         i_table_select,
    input  logic [9:0]         i_word_address,
    input  logic signed [31:0] i_word_value,
    input  logic signed [31:0] i_x_position,
    input  logic signed [31:0] i_y_position,
    input  logic signed [31:0] i_x_offset,
    input  logic signed [31:0] i_y_offset,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_value
);

    t_cmd  cmd;
    t_stat stat;

    bti_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bti_dp #(
        .NUM_TABLES  (NUM_TABLES),
        .TABLE_WORDS (TABLE_WORDS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_table_select (i_table_select),
        .i_word_address (i_word_address),
        .i_word_value   (i_word_value),
        .i_x_position   (i_x_position),
        .i_y_position   (i_y_position),
        .i_x_offset     (i_x_offset),
        .i_y_offset     (i_y_offset),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_value        (o_value)
    );

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("result loaded over a pending transfer");

    a_wr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.wr |-> (i_in_valid && !o_in_stall && !i_op))
        else $error("table write outside an accepted write transfer");

    a_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> (o_value == 32'd0))
        else $error("nonzero value with failing status");

    a_start_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_start |=> !cmd.div_start)
        else $error("divider restarted back to back");

endmodule

FILE: design/bti_div.sv
// Radix-2 restoring divider: 34-bit integer quotient plus 16 fraction bits.
// Uses nothing from the package.
module bti_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [33:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [33:0] o_quot,
    output logic [15:0] o_frac
);

    localparam int QW = 50;

    logic [QW-1:0] r_sh;
    logic [31:0]   r_rem;
    logic [31:0]   r_dv;
    logic [5:0]    r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [32:0]   trial;
    logic          ge;

    assign trial = {r_rem, r_sh[QW-1]};
    assign ge    = trial >= {1'b0, r_dv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 6'd1;
            if (r_cnt == 6'(QW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh  <= {i_dividend, 16'd0};
            r_rem <= '0;
            r_dv  <= i_divisor;
        end else if (r_busy) begin
            r_sh  <= {r_sh[QW-2:0], ge};
            r_rem <= ge ? 32'(trial - {1'b0, r_dv}) : trial[31:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_sh[QW-1:16];
    assign o_frac = r_sh[15:0];

endmodule

FILE: design/bti_ctrl.sv
// Sequencer for table writes and interpolation lookups.
// Depends on bti_pkg for the command and status structs.
module bti_ctrl import bti_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_op,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_RD   = 13'b0000000000010,
        S_CAP  = 13'b0000000000100,
        S_AXS  = 13'b0000000001000,
        S_DIVW = 13'b0000000010000,
        S_GMUL = 13'b0000000100000,
        S_GCHK = 13'b0000001000000,
        S_M1   = 13'b0000010000000,
        S_M2   = 13'b0000100000000,
        S_A1   = 13'b0001000000000,
        S_M3   = 13'b0010000000000,
        S_A2   = 13'b0100000000000,
        S_OUT  = 13'b1000000000000
    } t_state;

    t_state     r_state, n_state;
    logic [3:0] r_slot, n_slot;
    logic       r_axis, n_axis;
    t_status    r_status, n_status;
    logic       acc;

    assign o_in_stall = (r_state != S_IDLE);
    assign acc        = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_slot   = r_slot;
        n_axis   = r_axis;
        n_status = r_status;
        o_cmd        = '0;
        o_cmd.slot   = r_slot;
        o_cmd.axis   = r_axis;
        o_cmd.status = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (i_op == OP_WRITE) begin
                        o_cmd.wr = 1'b1;
                    end else begin
                        o_cmd.load_in = 1'b1;
                        n_slot = '0;
                        n_axis = 1'b0;
                        if (i_stat.sel_ok) begin
                            n_state = S_RD;
                        end else begin
                            n_status = ST_BAD_TABLE;
                            n_state  = S_OUT;
                        end
                    end
                end
            end
            S_RD: n_state = S_CAP;
            S_CAP: begin
                o_cmd.cap = 1'b1;
                n_slot    = r_slot + 4'd1;
                if (r_slot == SLOT_LAST_HDR) begin
                    n_state = S_AXS;
                end else if (r_slot == SLOT_LAST_GRD) begin
                    n_state = S_M1;
                end else begin
                    n_state = S_RD;
                end
            end
            S_AXS: begin
                if (i_stat.pre_fail) begin
                    n_status = ST_RANGE;
                    n_state  = S_OUT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIVW;
                end
            end
            S_DIVW: begin
                if (i_stat.div_done) begin
                    if (i_stat.idx_fail) begin
                        n_status = ST_RANGE;
                        n_state  = S_OUT;
                    end else begin
                        o_cmd.cap_ax = 1'b1;
                        n_axis  = 1'b1;
                        n_state = r_axis ? S_GMUL : S_AXS;
                    end
                end
            end
            S_GMUL: begin
                o_cmd.mul_n = 1'b1;
                n_state = S_GCHK;
            end
            S_GCHK: begin
                if (i_stat.grid_fail) begin
                    n_status = ST_RANGE;
                    n_state  = S_OUT;
                end else begin
                    o_cmd.n_load = 1'b1;
                    n_slot  = SLOT_FIRST_GRD;
                    n_state = S_RD;
                end
            end
            S_M1: begin
                o_cmd.m1 = 1'b1;
                n_state = S_M2;
            end
            S_M2: begin
                o_cmd.m2 = 1'b1;
                n_state = S_A1;
            end
            S_A1: begin
                o_cmd.a1 = 1'b1;
                n_state = S_M3;
            end
            S_M3: begin
                o_cmd.m3 = 1'b1;
                n_state = S_A2;
            end
            S_A2: begin
                o_cmd.a2 = 1'b1;
                n_status = ST_OK;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_slot   <= '0;
            r_axis   <= 1'b0;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_slot   <= n_slot;
            r_axis   <= n_axis;
            r_status <= n_status;
        end
    end

endmodule

FILE: design/bti_dp.sv
// Datapath: table memory, axis divide, grid addressing, blend and result register.
// Depends on bti_pkg and bti_div.
module bti_dp import bti_pkg::*; #(
    parameter int NUM_TABLES  = NUM_TABLES_DEF,
    parameter int TABLE_WORDS = TABLE_WORDS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic [3:0]         i_table_select,
    input  logic [9:0]         i_word_address,
    input  logic signed [31:0] i_word_value,
    input  logic signed [31:0] i_x_position,
    input  logic signed [31:0] i_y_position,
    input  logic signed [31:0] i_x_offset,
    input  logic signed [31:0] i_y_offset,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_value
);

    localparam int DEPTH = NUM_TABLES * TABLE_WORDS;
    localparam int MAW   = $clog2(DEPTH);
    localparam int CW    = $clog2(TABLE_WORDS) + 1;
    localparam int NW    = 2 * CW + 1;

    logic [31:0]        r_mem [DEPTH];
    logic [31:0]        r_rdata;
    logic [31:0]        r_words [NUM_SLOTS];
    logic [MAW-1:0]     r_base;
    logic signed [32:0] r_xs, r_ys;
    logic [33:0]        r_ix, r_iy;
    logic [15:0]        r_fx, r_fy;
    logic [2*CW-1:0]    r_nprod;
    logic [NW-1:0]      r_n;
    logic signed [52:0] r_p, r_p2;
    logic signed [34:0] r_r1, r_r2;
    logic signed [31:0] r_v;
    logic               r_ovalid;
    logic [1:0]         r_ostatus;
    logic [31:0]        r_ovalue;

    logic               sel_ok;
    logic [MAW-1:0]     in_base, raddr, goff;
    logic signed [32:0] pos_sum;
    logic signed [31:0] start, step, count;
    logic signed [33:0] d;
    logic [33:0]        ad;
    logic [31:0]        as_;
    logic               div_done;
    logic [33:0]        quot;
    logic [15:0]        frac;
    logic [CW-1:0]      xc_n;
    logic [NW:0]        need;
    logic signed [35:0] dlo, dhi, dv;
    logic signed [36:0] vsum;

    function automatic logic signed [36:0] rnd16(input logic signed [52:0] p);
        logic signed [52:0] t;
        t = p + 53'sd32768;
        return t[52:16];
    endfunction

    assign sel_ok  = (i_table_select >= 4'd1) && (32'(i_table_select) <= 32'(NUM_TABLES));
    assign in_base = MAW'((32'(i_table_select) - 32'd1) * 32'(TABLE_WORDS));

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && sel_ok && (32'(i_word_address) < 32'(TABLE_WORDS))) begin
            r_mem[MAW'(in_base + MAW'(i_word_address))] <= i_word_value;
        end
        r_rdata <= r_mem[raddr];
    end

    assign xc_n = r_words[2][CW-1:0];

    always_comb begin
        case (i_cmd.slot)
            4'd6:    goff = '0;
            4'd7:    goff = MAW'(1);
            4'd8:    goff = MAW'(xc_n);
            default: goff = MAW'(xc_n) + MAW'(1);
        endcase
        if (i_cmd.slot <= SLOT_LAST_HDR) begin
            raddr = r_base + MAW'(i_cmd.slot);
        end else begin
            raddr = r_base + MAW'(HDR_WORDS) + MAW'(r_n) + goff;
        end
    end

    assign pos_sum = i_cmd.axis ? r_ys : r_xs;
    assign start   = i_cmd.axis ? r_words[3] : r_words[0];
    assign step    = i_cmd.axis ? r_words[4] : r_words[1];
    assign count   = i_cmd.axis ? r_words[5] : r_words[2];
    assign d       = 34'(pos_sum) - 34'(start);
    assign ad      = d[33] ? 34'(-d) : 34'(d);
    assign as_     = step[31] ? 32'(-step) : 32'(step);

    bti_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (ad),
        .i_divisor  (as_),
        .o_done     (div_done),
        .o_quot     (quot),
        .o_frac     (frac)
    );

    assign need = (NW+1)'(HDR_WORDS) + (NW+1)'(r_ix[CW-1:0]) + (NW+1)'(r_nprod)
                + (NW+1)'(xc_n) + (NW+1)'(1);

    assign o_stat.sel_ok   = sel_ok;
    assign o_stat.pre_fail = (step == 32'sd0) || (count < 32'sd2)
                           || ((d != 34'sd0) && (d[33] != step[31]));
    assign o_stat.div_done = div_done;
    assign o_stat.idx_fail = quot >= ({2'b00, count} - 34'd1);
    assign o_stat.grid_fail = (r_ix >= 34'(TABLE_WORDS)) || (r_iy >= 34'(TABLE_WORDS))
                            || ($unsigned(r_words[2]) >= 32'(TABLE_WORDS))
                            || (need >= (NW+1)'(TABLE_WORDS));
    assign o_stat.out_free = !r_ovalid || !i_out_stall;

    assign dlo  = 36'($signed(r_words[7])) - 36'($signed(r_words[6]));
    assign dhi  = 36'($signed(r_words[9])) - 36'($signed(r_words[8]));
    assign dv   = 36'(r_r2) - 36'(r_r1);
    assign vsum = 37'(r_r1) + rnd16(r_p);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_base <= in_base;
            r_xs   <= 33'(i_x_position) + 33'(i_x_offset);
            r_ys   <= 33'(i_y_position) + 33'(i_y_offset);
        end
        if (i_cmd.cap) begin
            r_words[i_cmd.slot] <= r_rdata;
        end
        if (i_cmd.cap_ax) begin
            if (i_cmd.axis) begin
                r_iy <= quot;
                r_fy <= frac;
            end else begin
                r_ix <= quot;
                r_fx <= frac;
            end
        end
        if (i_cmd.mul_n) begin
            r_nprod <= r_iy[CW-1:0] * xc_n;
        end
        if (i_cmd.n_load) begin
            r_n <= NW'(r_ix[CW-1:0]) + NW'(r_nprod);
        end
        if (i_cmd.m1) begin
            r_p <= dlo * $signed({1'b0, r_fx});
        end
        if (i_cmd.m2) begin
            r_p2 <= dhi * $signed({1'b0, r_fx});
        end
        if (i_cmd.a1) begin
            r_r1 <= 35'($signed(r_words[6])) + 35'(rnd16(r_p));
            r_r2 <= 35'($signed(r_words[8])) + 35'(rnd16(r_p2));
        end
        if (i_cmd.m3) begin
            r_p <= dv * $signed({1'b0, r_fy});
        end
        if (i_cmd.a2) begin
            if (vsum > 37'sd2147483647) begin
                r_v <= 32'sh7FFFFFFF;
            end else if (vsum < -37'sd2147483648) begin
                r_v <= 32'sh80000000;
            end else begin
                r_v <= 32'(vsum);
            end
        end
        if (i_cmd.out_load) begin
            r_ostatus <= i_cmd.status;
            r_ovalue  <= (i_cmd.status == ST_OK) ? r_v : 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_status    = r_ostatus;
    assign o_value     = r_ovalue;

endmodule
